### hw/rtl/wpf_pkg.sv
package wpf_pkg;

    // default sizes, handed to the top level parameters
    localparam int MAX_PATTERN_DEF  = 8;
    localparam int MAX_WORD_LEN_DEF = 32;

    // fixed field widths
    localparam int CHAR_W       = 8;
    localparam int PAT_BYTES    = 8;
    localparam int PAT_W        = PAT_BYTES * CHAR_W;
    localparam int PAT_IDX_W    = $clog2(PAT_BYTES);
    localparam int PLEN_W       = 4;
    localparam int MODE_W       = 3;
    localparam int COUNT_W      = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;

    // letter statistics
    localparam int LETTERS      = 26;
    localparam int LETTER_CNT_W = 6;
    localparam int NEED_W       = 4;
    localparam logic [CHAR_W-1:0]       CHAR_A     = 8'h61;
    localparam logic [LETTER_CNT_W-1:0] LETTER_MAX = 6'd63;

    // filter modes
    typedef enum logic [MODE_W-1:0] {
        MODE_PREFIX   = 3'd0,
        MODE_MIDDLE   = 3'd1,
        MODE_SUFFIX   = 3'd2,
        MODE_ANYWHERE = 3'd3,
        MODE_EXCLUDE  = 3'd4,
        MODE_LETTERS  = 3'd5
    } mode_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_MODE    = 2'd0,
        CFG_PATTERN_CHARS  = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    // control into one window cell
    typedef struct packed {
        logic advance;
        logic win_en;
        logic pat_en;
    } cell_ctrl_t;

    // status out of one window cell
    typedef struct packed {
        logic win_hit;
        logic pat_hit;
    } cell_stat_t;

endpackage

### hw/rtl/wpf_cell.sv
module wpf_cell
    import wpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [CHAR_W-1:0] shift_in,
    input  logic [CHAR_W-1:0] win_ref,
    input  logic [CHAR_W-1:0] pat_ref,
    input  logic [CHAR_W-1:0] char_code,
    output logic [CHAR_W-1:0] shift_out,
    output cell_stat_t        stat
);

    logic [CHAR_W-1:0] byte_reg;

    // window byte, moves one cell along per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            byte_reg <= shift_in;
        end
    end

    assign shift_out = byte_reg;

    // byte landing here this item against its pattern position
    assign stat.win_hit = !ctrl.win_en || (shift_in == win_ref);

    // incoming character against this cell's pattern byte
    assign stat.pat_hit = ctrl.pat_en && (char_code == pat_ref);

endmodule

### hw/rtl/wpf_letter_bank.sv
module wpf_letter_bank
    import wpf_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              clear,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [PAT_W-1:0]  pattern_chars,
    input  logic [PLEN_W-1:0] pat_len,
    output logic              letters_ok
);

    logic [LETTER_CNT_W-1:0] cnt_reg  [LETTERS];
    logic [LETTER_CNT_W-1:0] cnt_next [LETTERS];
    logic [LETTERS-1:0]      letter_ok;

    for (genvar l = 0; l < LETTERS; l++)
    begin : g_letter
        logic [CHAR_W-1:0] letter_code;
        logic [NEED_W-1:0] need;

        assign letter_code = CHAR_A + CHAR_W'(l);

        // saturating count of this letter, including the current item
        always_comb
        begin
            cnt_next[l] = cnt_reg[l];
            if (char_code == letter_code && cnt_reg[l] < LETTER_MAX)
            begin
                cnt_next[l] = cnt_reg[l] + LETTER_CNT_W'(1);
            end
        end

        // how often the pattern asks for this letter
        always_comb
        begin
            need = '0;
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                if (PLEN_W'(j) < pat_len &&
                    pattern_chars[j*CHAR_W +: CHAR_W] == letter_code)
                begin
                    need = need + NEED_W'(1);
                end
            end
        end

        assign letter_ok[l] = cnt_next[l] >= LETTER_CNT_W'(need);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg[l] <= '0;
            end
            else if (advance)
            begin
                cnt_reg[l] <= clear ? '0 : cnt_next[l];
            end
        end
    end

    assign letters_ok = &letter_ok;

endmodule

### hw/rtl/word_pattern_filter.sv
// channel  | handshake              | payload
// ---------+------------------------+------------------------------
// in       | in_valid / in_stall    | char_code[7:0], last_char
// out      | out_valid / out_stall  | keep_word, word_length[5:0]
// cfg      | cfg_valid / cfg_ready  | cfg_index[1:0], cfg_data[63:0]
//
// one character per cycle while in_stall is low; the window cells and letter
// counters all update on the cycle the character is taken
// the result of a word is registered into the output buffer as its last character is taken
// a two-entry output buffer holds results; in_stall rises only when both
// entries are full, so the input keeps flowing while one result waits
// reset clears all word state at once, no clearing pass
module word_pattern_filter
    import wpf_pkg::*;
#(
    parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic                  last_char,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  keep_word,
    output logic [COUNT_W-1:0]    word_length,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_WORD_LEN);

    mode_t              filter_mode_reg;
    logic [PAT_W-1:0]   pattern_chars_reg;
    logic [PLEN_W-1:0]  pattern_length_reg;
    logic [PLEN_W-1:0]  pat_len;

    logic               in_accept;
    logic               push;
    logic               pop;

    logic [COUNT_W-1:0] char_count_reg;
    logic [COUNT_W-1:0] char_count_next;
    logic               seen_anywhere_reg;
    logic               seen_anywhere_next;
    logic               seen_at_start_reg;
    logic               seen_at_start_next;
    logic               excluded_hit_reg;
    logic               excluded_hit_next;
    logic               enough;
    logic               suffix;
    logic               letters_ok;
    logic               keep;

    logic [CHAR_W-1:0]      win_chain [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] win_hits;
    logic [MAX_PATTERN-1:0] pat_hits;

    logic               out_valid_reg;
    logic               keep_reg;
    logic [COUNT_W-1:0] length_reg;
    logic               skid_valid_reg;
    logic               skid_keep_reg;
    logic [COUNT_W-1:0] skid_length_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign push      = in_accept && last_char;
    assign pop       = out_valid_reg && !out_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg    <= MODE_ANYWHERE;
            pattern_chars_reg  <= '0;
            pattern_length_reg <= PLEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FILTER_MODE:    filter_mode_reg    <= mode_t'(cfg_data[MODE_W-1:0]);
                CFG_PATTERN_CHARS:  pattern_chars_reg  <= cfg_data[PAT_W-1:0];
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[PLEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // effective pattern length, clamped to one..MAX_PATTERN
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            pat_len = PLEN_W'(1);
        end
        else if (pattern_length_reg > PLEN_W'(MAX_PATTERN))
        begin
            pat_len = PLEN_W'(MAX_PATTERN);
        end
        else
        begin
            pat_len = pattern_length_reg;
        end
    end

    // row of window cells, cell zero holds the newest character
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        logic [PLEN_W-1:0] win_pos;
        logic [CHAR_W-1:0] shift_in;
        cell_ctrl_t        ctrl;
        cell_stat_t        stat;

        assign win_pos = pat_len - PLEN_W'(k) - PLEN_W'(1);

        if (k == 0)
        begin : g_head
            assign shift_in = char_code;
        end
        else
        begin : g_body
            assign shift_in = win_chain[k-1];
        end

        assign ctrl.advance = in_accept;
        assign ctrl.win_en  = PLEN_W'(k) < pat_len;
        assign ctrl.pat_en  = PLEN_W'(k) < pat_len;

        wpf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .shift_in  (shift_in),
            .win_ref   (pattern_chars_reg[win_pos[PAT_IDX_W-1:0]*CHAR_W +: CHAR_W]),
            .pat_ref   (pattern_chars_reg[k*CHAR_W +: CHAR_W]),
            .char_code (char_code),
            .shift_out (win_chain[k]),
            .stat      (stat)
        );

        assign win_hits[k] = stat.win_hit;
        assign pat_hits[k] = stat.pat_hit;
    end

    // per-letter counters for the letter requirement
    wpf_letter_bank #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_letters (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (in_accept),
        .clear         (last_char),
        .char_code     (char_code),
        .pattern_chars (pattern_chars_reg),
        .pat_len       (pat_len),
        .letters_ok    (letters_ok)
    );

    // word tracking for the current item
    always_comb
    begin
        char_count_next = char_count_reg;
        if (char_count_reg < COUNT_MAX)
        begin
            char_count_next = char_count_reg + COUNT_W'(1);
        end
        enough             = char_count_next >= COUNT_W'(pat_len);
        suffix             = enough && (&win_hits);
        seen_anywhere_next = seen_anywhere_reg || suffix;
        seen_at_start_next = seen_at_start_reg ||
            (suffix && ({1'b0, char_count_reg} + (COUNT_W+1)'(1)) == (COUNT_W+1)'(pat_len));
        excluded_hit_next  = excluded_hit_reg || (|pat_hits);
    end

    // filter decision at the end of a word
    always_comb
    begin
        unique case (filter_mode_reg)
            MODE_PREFIX:   keep = seen_at_start_next;
            MODE_MIDDLE:   keep = seen_anywhere_next && !seen_at_start_next && !suffix;
            MODE_SUFFIX:   keep = suffix;
            MODE_ANYWHERE: keep = seen_anywhere_next;
            MODE_EXCLUDE:  keep = !excluded_hit_next;
            MODE_LETTERS:  keep = letters_ok;
            default:       keep = 1'b0;
        endcase
    end

    // word state, cleared after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg    <= '0;
            seen_anywhere_reg <= 1'b0;
            seen_at_start_reg <= 1'b0;
            excluded_hit_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            if (last_char)
            begin
                char_count_reg    <= '0;
                seen_anywhere_reg <= 1'b0;
                seen_at_start_reg <= 1'b0;
                excluded_hit_reg  <= 1'b0;
            end
            else
            begin
                char_count_reg    <= char_count_next;
                seen_anywhere_reg <= seen_anywhere_next;
                seen_at_start_reg <= seen_at_start_next;
                excluded_hit_reg  <= excluded_hit_next;
            end
        end
    end

    // two-entry output buffer: output register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                keep_reg   <= skid_keep_reg;
                length_reg <= skid_length_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_keep_reg   <= keep;
                skid_length_reg <= char_count_next;
            end
            else
            begin
                keep_reg   <= keep;
                length_reg <= char_count_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign keep_word   = keep_reg;
    assign word_length = length_reg;

    // a held skid entry always sits behind a valid output
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a valid output");

    // taking the head moves the skid entry forward
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved forward");

    // word state is cleared after the last character
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_char) |=>
            (char_count_reg == '0 && !seen_anywhere_reg && !excluded_hit_reg))
        else $error("word state not cleared at end of word");

    // length count stays within its saturation limit
    assert property (@(posedge clk) disable iff (!rst_n)
        char_count_reg <= COUNT_MAX)
        else $error("character count above saturation limit");

    // a prefix match is also a match somewhere
    assert property (@(posedge clk) disable iff (!rst_n)
        seen_at_start_reg |-> seen_anywhere_reg)
        else $error("prefix seen without any match");

endmodule

### tb/tb_word_pattern_filter.sv
module tb_word_pattern_filter;
    import wpf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // modes outside the defined set
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
    localparam logic [CHAR_W-1:0] CHAR_Z = CHAR_A + 8'd25;
    localparam int unsigned TOTAL_CHARS = 450;
    localparam int unsigned SETTLE_CYCLES = 4;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              fin;
    } char_item_t;

    typedef struct {
        logic               keep;
        logic [COUNT_W-1:0] len;
    } word_verdict_t;

    typedef enum {AT_START, AT_END, IN_MIDDLE, AT_RANDOM, NOWHERE} spot_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [CHAR_W-1:0]     char_code;
    logic                  last_char;
    logic                  out_valid;
    logic                  out_stall;
    logic                  keep_word;
    logic [COUNT_W-1:0]    word_length;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // register copies as the block should hold them
    logic [MODE_W-1:0]     cur_mode = MODE_ANYWHERE;
    logic [PAT_W-1:0]      cur_pattern = '0;
    logic [PLEN_W-1:0]     cur_plen = 4'd1;

    // per-word state of the predictor
    logic [CHAR_W-1:0]       recent [MAX_PATTERN_DEF];
    int unsigned             char_count;
    bit                      seen_any;
    bit                      seen_start;
    bit                      excl_hit;
    logic [LETTER_CNT_W-1:0] letter_cnt [LETTERS];

    char_item_t    char_backlog [$];
    word_verdict_t pending_verdicts [$];

    bit          char_taken;
    bit          cfg_taken;
    bit          calm;
    int unsigned in_gap;
    int unsigned out_gap;
    int unsigned chars_queued;
    int unsigned chars_taken;
    int unsigned words_checked;
    int unsigned reg_writes;
    int unsigned mismatches;

    word_pattern_filter i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .last_char   (last_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .keep_word   (keep_word),
        .word_length (word_length),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // effective pattern length, clamped to 1..MAX_PATTERN
    function automatic int unsigned span();
        if (cur_plen == 0)
            return 1;
        if (cur_plen > MAX_PATTERN_DEF)
            return MAX_PATTERN_DEF;
        return 32'(cur_plen);
    endfunction

    function automatic logic [CHAR_W-1:0] pat_char(input int unsigned i);
        return cur_pattern[(i % PAT_BYTES) * CHAR_W +: CHAR_W];
    endfunction

    function automatic void clear_word_state();
        foreach (recent[k])
            recent[k] = '0;
        foreach (letter_cnt[k])
            letter_cnt[k] = '0;
        char_count = 0;
        seen_any   = 1'b0;
        seen_start = 1'b0;
        excl_hit   = 1'b0;
    endfunction

    // advance the word state by one character, give the verdict at word end
    task automatic scan_char(input logic [CHAR_W-1:0] c, input logic fin,
                             output bit done, output word_verdict_t v);
        int unsigned n;
        int unsigned prior;
        int unsigned need;
        bit tail;
        bit ok;
        logic [CHAR_W-1:0] p;
        n = span();
        prior = char_count;
        done = fin;
        v.keep = 1'b0;
        v.len = '0;

        // shift window, newest in entry 0
        for (int k = MAX_PATTERN_DEF - 1; k > 0; k--)
            recent[k] = recent[k-1];
        recent[0] = c;
        if (char_count < MAX_WORD_LEN_DEF)
            char_count++;

        for (int k = 0; k < n; k++)
            if (pat_char(k) == c)
                excl_hit = 1'b1;
        if (c >= CHAR_A && c <= CHAR_Z)
            if (letter_cnt[c - CHAR_A] < LETTER_MAX)
                letter_cnt[c - CHAR_A]++;

        // does the window end with the pattern
        tail = (char_count >= n);
        for (int k = 0; k < n; k++)
            if (recent[k] != pat_char(n - 1 - k))
                tail = 1'b0;
        if (tail)
            seen_any = 1'b1;
        if (prior + 1 == n && tail)
            seen_start = 1'b1;

        if (!fin)
            return;

        case (cur_mode)
            MODE_PREFIX:   ok = seen_start;
            MODE_MIDDLE:   ok = seen_any && !seen_start && !tail;
            MODE_SUFFIX:   ok = tail;
            MODE_ANYWHERE: ok = seen_any;
            MODE_EXCLUDE:  ok = !excl_hit;
            MODE_LETTERS:
            begin
                ok = 1'b1;
                for (int i = 0; i < n; i++)
                begin
                    p = pat_char(i);
                    if (p >= CHAR_A && p <= CHAR_Z)
                    begin
                        need = 0;
                        for (int j = 0; j < n; j++)
                            if (pat_char(j) == p)
                                need++;
                        if (letter_cnt[p - CHAR_A] < need)
                            ok = 1'b0;
                    end
                end
            end
            default:       ok = 1'b0;
        endcase
        v.keep = ok;
        v.len = COUNT_W'(char_count);
        clear_word_state();
    endtask

    // monitor: register writes, accepted characters and results
    always @(posedge clk)
    begin
        word_verdict_t want;
        word_verdict_t got;
        bit ends_word;
        char_taken = 1'b0;
        cfg_taken = 1'b0;
        if (!rst_n)
        begin
            clear_word_state();
            cur_mode = MODE_ANYWHERE;
            cur_pattern = '0;
            cur_plen = 4'd1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_taken = 1'b1;
                case (cfg_index)
                    CFG_FILTER_MODE:    cur_mode = cfg_data[MODE_W-1:0];
                    CFG_PATTERN_CHARS:  cur_pattern = cfg_data;
                    CFG_PATTERN_LENGTH: cur_plen = cfg_data[PLEN_W-1:0];
                    default:            ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                char_taken = 1'b1;
                chars_taken++;
                scan_char(char_code, last_char, ends_word, want);
                if (ends_word)
                    pending_verdicts.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                got.keep = keep_word;
                got.len = word_length;
                if (pending_verdicts.size() == 0)
                begin
                    $error("result with no word pending: keep_word %0b word_length %0d",
                           got.keep, got.len);
                    mismatches++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    words_checked++;
                    if (got.keep !== want.keep)
                    begin
                        $error("keep_word expected %0b actual %0b", want.keep, got.keep);
                        mismatches++;
                    end
                    if (got.len !== want.len)
                    begin
                        $error("word_length expected %0d actual %0d", want.len, got.len);
                        mismatches++;
                    end
                end
            end
        end
    end

    // character driver, fed from the backlog
    always @(negedge clk)
    begin
        char_item_t nxt;
        bit send;
        if (rst_n && (!in_valid || char_taken))
        begin
            send = 1'b0;
            if (in_gap > 0)
                in_gap--;
            else if (char_backlog.size() != 0)
            begin
                if (!calm && $urandom_range(0, 7) == 0)
                    in_gap = $urandom_range(0, 4);
                else
                begin
                    nxt = char_backlog.pop_front();
                    send = 1'b1;
                    char_code <= nxt.code;
                    last_char <= nxt.fin;
                end
            end
            in_valid <= send;
        end
    end

    // result side stall bursts
    always @(negedge clk)
    begin
        bit hold;
        hold = 1'b0;
        if (out_gap > 0)
        begin
            out_gap--;
            hold = 1'b1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            out_gap = $urandom_range(0, 4);
            hold = 1'b1;
        end
        out_stall <= hold;
    end

    task automatic queue_char(input logic [CHAR_W-1:0] c, input logic fin);
        char_item_t it;
        it.code = c;
        it.fin = fin;
        char_backlog.push_back(it);
        chars_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], i == s.len() - 1);
    endtask

    // mostly a small alphabet so that pattern hits are common
    function automatic logic [CHAR_W-1:0] filler();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return CHAR_A + CHAR_W'($urandom_range(0, 3));
        if (r == 7)
            return pat_char($urandom_range(0, PAT_BYTES - 1));
        if (r == 8)
            return CHAR_W'($urandom_range(0, 255));
        return CHAR_A + CHAR_W'($urandom_range(0, 25));
    endfunction

    // one word, with the pattern planted at a random place or nowhere
    task automatic queue_word(input int unsigned wlen, input bit close);
        logic [CHAR_W-1:0] w [$];
        int unsigned n;
        int unsigned at;
        spot_t place;
        n = span();
        for (int i = 0; i < wlen; i++)
            w.push_back(filler());
        place = spot_t'($urandom_range(0, 4));
        if (wlen >= n && place != NOWHERE)
        begin
            case (place)
                AT_START:  at = 0;
                AT_END:    at = wlen - n;
                IN_MIDDLE: at = (wlen >= n + 2) ? $urandom_range(1, wlen - n - 1) : 0;
                default:   at = $urandom_range(0, wlen - n);
            endcase
            for (int k = 0; k < n; k++)
                w[at + k] = pat_char(k);
        end
        foreach (w[i])
            queue_char(w[i], close && i == wlen - 1);
    endtask

    // wait for every character and result, then let the block go quiet
    task automatic drain();
        while (chars_taken != chars_queued || pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_all(input logic [MODE_W-1:0] mode, input logic [PAT_W-1:0] pat,
                           input logic [PLEN_W-1:0] plen);
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_PATTERN_CHARS, pat);
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(plen));
    endtask

    // random setting, some registers left as they were
    task automatic pick_setting();
        logic [PAT_W-1:0] pat;
        int unsigned r;
        r = $urandom_range(0, 9);
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_FILTER_MODE,
                      CFG_DATA_W'((r < 8) ? r : $urandom_range(0, 5)));
        r = $urandom_range(0, 7);
        if (r == 6)
            pat = {$urandom, $urandom};
        else
            for (int k = 0; k < PAT_BYTES; k++)
                pat[k*CHAR_W +: CHAR_W] = CHAR_A + CHAR_W'((r < 6) ? $urandom_range(0, 3)
                                                                   : $urandom_range(0, 25));
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_PATTERN_CHARS, pat);
        r = $urandom_range(0, 9);
        if (r < 6)
            r = $urandom_range(1, 4);
        else if (r == 6)
            r = 0;
        else if (r == 7)
            r = $urandom_range(9, 15);
        else
            r = $urandom_range(5, 8);
        if ($urandom_range(0, 3) != 0)
            write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(r));
    endtask

    // a run of words, optionally leaving the last one open across the next writes
    task automatic run_phase(input int unsigned budget, input bit leave_open);
        int unsigned used;
        int unsigned wlen;
        used = 0;
        while (used < budget)
        begin
            wlen = ($urandom_range(0, 14) == 0) ? $urandom_range(33, 70)
                                                : $urandom_range(1, 12);
            queue_word(wlen, 1'b1);
            used += wlen;
        end
        if (leave_open)
            queue_word($urandom_range(1, 6), 1'b0);
        drain();
    endtask

    initial
    begin
        int unsigned target;
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_code = '0;
        last_char = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FILTER_MODE;
        cfg_data = '0;
        calm = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset setting, extreme bytes
        queue_char(8'h00, 1'b1);
        queue_char(8'hFF, 1'b1);
        drain();

        // directed: every mode but anywhere, and an undefined mode, against a three letter pattern
        set_all(MODE_PREFIX, 64'h616E61, 4'd3);
        queue_text("anab");
        drain();
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_MIDDLE));
        queue_text("banab");
        drain();
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_SUFFIX));
        queue_text("an");
        drain();
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_EXCLUDE));
        queue_text("xyz");
        drain();
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_LETTERS));
        queue_text("naan");
        drain();
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_UNUSED_LO));
        queue_text("a");
        drain();

        // extreme settings, open words carried across the writes
        calm = 1'b0;
        set_all(MODE_LETTERS, '1, 4'd15);
        run_phase(40, 1'b1);
        set_all(MODE_UNUSED_HI, '0, 4'd0);
        run_phase(30, 1'b1);
        set_all(MODE_MIDDLE, 64'h6261626162616261, 4'd8);
        run_phase(40, 1'b0);
        set_all(MODE_LETTERS, 64'h21623161, 4'd4);
        run_phase(30, 1'b1);

        // random settings and words, up to the overall item count
        target = TOTAL_CHARS - 40;
        while (chars_queued < target)
        begin
            calm = ($urandom_range(0, 3) == 0);
            pick_setting();
            run_phase($urandom_range(25, 60), $urandom_range(0, 2) == 0);
        end

        // closing stretch with no idling on either side
        calm = 1'b1;
        pick_setting();
        run_phase(40, 1'b0);

        $display("checked %0d words from %0d characters over %0d register writes",
                 words_checked, chars_taken, reg_writes);
        if (mismatches == 0)
            $display("[word_pattern_filter] OK");
        else
            $display("[word_pattern_filter] ERROR");
        $finish;
    end

    // overall time limit
    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", pending_verdicts.size());
        $display("[word_pattern_filter] ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/wpf_pkg.sv
hw/rtl/wpf_cell.sv
hw/rtl/wpf_letter_bank.sv
hw/rtl/word_pattern_filter.sv
tb/tb_word_pattern_filter.sv
